### hw/rtl/mgbh_pkg.sv
// shared types and constants for the modular golden byte hash
package mgbh_pkg;

	localparam int WORD_W        = 64;
	localparam int ROOT_W        = 33;
	localparam int DIGEST_W      = 63;
	localparam int PADDR_W       = 6;
	localparam int SECRET_WORDS_DEF = 24;

	localparam logic [1:0] CMD_BUILD   = 2'd0;
	localparam logic [1:0] CMD_ABSORB  = 2'd1;
	localparam logic [1:0] CMD_FINISH  = 2'd2;
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	localparam logic RESULT_TABLE  = 1'b0;
	localparam logic RESULT_DIGEST = 1'b1;

	localparam logic [2:0] REG_TABLE_SIZE = 3'd0;
	localparam logic [2:0] REG_MODULUS    = 3'd1;
	localparam logic [2:0] REG_HIGH_PRIME = 3'd2;
	localparam logic [2:0] REG_LOW_PRIME  = 3'd3;
	localparam logic [2:0] REG_AVALANCHE  = 3'd4;
	localparam logic [2:0] REG_ROOT_DIV   = 3'd5;

	typedef struct packed {
		logic start;
		logic div;
	} alu_req_t;

endpackage

### hw/rtl/mgbh_in_if.sv
// input channel of the hash block
interface mgbh_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] byte_value;
	logic       is_last;

	modport source (output valid, command, byte_value, is_last, input ready);
	modport sink (input valid, command, byte_value, is_last, output ready);
endinterface

### hw/rtl/mgbh_out_if.sv
// result channel of the hash block
interface mgbh_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [62:0] digest;

	modport source (output valid, result_kind, digest, input ready);
	modport sink (input valid, result_kind, digest, output ready);
endinterface

### hw/rtl/modular_golden_byte_hash.sv
// modular byte hash: sequencer around a shared bit-serial multiply/divide unit
// each multiply or divide runs bit-serially in the shared unit; an absorbed byte costs
// six of them, a finish eight, a last byte both, a table build 168 (with the default
// table of 24 words); one transaction is in work at a time
// reset clears the registers to their defaults and the running hash and position;
// the secret table holds no value until the first build
module modular_golden_byte_hash #(
	parameter int SECRET_WORDS = mgbh_pkg::SECRET_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mgbh_in_if.sink                     in_ch,
	mgbh_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mgbh_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);
	import mgbh_pkg::*;

	localparam int AW = SECRET_WORDS > 1 ? $clog2(SECRET_WORDS) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_B_MUL1, S_B_D33, S_B_RED1, S_B_MUL2, S_B_RED2, S_B_D29, S_B_RED3,
		S_B_NEXT, S_A_RD, S_A_RED1, S_A_MUL1, S_A_RED2, S_A_MUL2, S_A_MUL3, S_A_RED3,
		S_F_D1, S_F_Q1, S_F_RED1, S_F_MUL, S_F_RED2, S_F_Q2, S_F_RED3, S_F_REDT, S_EMIT
	} state_t;

	state_t st_q;
	logic [WORD_W-1:0] tsize_q, mod_q, hp_q, lp_q, av_q;
	logic [ROOT_W-1:0] root_q;
	logic [WORD_W-1:0] acc_q, hash_q, pos_q, s_q, t_q, d1_q;
	logic [AW-1:0]     k_q, pidx_q;
	logic [7:0]        byte_q;
	logic              last_q, go_q, kind_q;
	logic              out_valid_q, out_kind_q;
	logic [DIGEST_W-1:0] out_digest_q;

	alu_req_t          req;
	logic [WORD_W-1:0] alu_a, alu_b, lo, hi, ram_rd, d2;
	logic              alu_done, compute, skip, wr_en;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= 64'd1024;
			mod_q   <= 64'd1024;
			hp_q    <= 64'd631;
			lp_q    <= 64'd389;
			av_q    <= 64'd241;
			root_q  <= 33'd32;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[5:3])
				REG_TABLE_SIZE: tsize_q <= pwdata;
				REG_MODULUS:    mod_q   <= pwdata;
				REG_HIGH_PRIME: hp_q    <= pwdata;
				REG_LOW_PRIME:  lp_q    <= pwdata;
				REG_AVALANCHE:  av_q    <= pwdata;
				REG_ROOT_DIV:   root_q  <= pwdata[ROOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_TABLE_SIZE: prdata = tsize_q;
			REG_MODULUS:    prdata = mod_q;
			REG_HIGH_PRIME: prdata = hp_q;
			REG_LOW_PRIME:  prdata = lp_q;
			REG_AVALANCHE:  prdata = av_q;
			REG_ROOT_DIV:   prdata = {{(WORD_W-ROOT_W){1'b0}}, root_q};
			default:        prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	assign d2 = (root_q < 33'd2) ? 64'd2 : {{(WORD_W-ROOT_W){1'b0}}, root_q};

	// operand selection for the shared unit
	always_comb begin
		compute = 1'b1;
		skip    = 1'b0;
		req.div = 1'b1;
		alu_a   = acc_q;
		alu_b   = mod_q;
		case (st_q)
			S_B_MUL1: begin req.div = 1'b0; alu_b = hp_q; end
			S_B_D33:  alu_b = 64'd33;
			S_B_D29:  alu_b = 64'd29;
			S_B_MUL2, S_A_MUL1: begin req.div = 1'b0; alu_b = lp_q; end
			S_A_MUL2: begin req.div = 1'b0; alu_a = pos_q; alu_b = s_q; end
			S_A_MUL3: begin req.div = 1'b0; alu_b = t_q; end
			S_F_D1:   begin alu_a = mod_q; alu_b = 64'd3; end
			S_F_Q1:   alu_b = d1_q;
			S_F_MUL:  begin req.div = 1'b0; alu_b = av_q; end
			S_F_Q2:   alu_b = d2;
			S_B_RED1, S_B_RED2, S_B_RED3, S_A_RED1, S_A_RED2, S_A_RED3,
			S_F_RED1, S_F_RED2, S_F_RED3: skip = (mod_q == '0);
			S_F_REDT: begin
				alu_b = tsize_q;
				skip  = (tsize_q == '0) || (mod_q == tsize_q);
			end
			default: compute = 1'b0;
		endcase
		req.start = compute && !skip && !go_q;
	end

	mgbh_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.res_lo (lo),
		.res_hi (hi)
	);

	assign wr_en = (st_q == S_B_NEXT);

	mgbh_ram #(.WIDTH(WORD_W), .DEPTH(SECRET_WORDS)) u_secret (
		.clk   (clk),
		.we    (wr_en),
		.waddr (k_q),
		.wdata (acc_q),
		.raddr (pidx_q),
		.rdata (ram_rd)
	);

	assign in_ch.ready = (st_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			go_q        <= 1'b0;
			hash_q      <= '0;
			pos_q       <= '0;
			pidx_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_EMIT the output register is reloaded below instead
			if (out_valid_q && out_ch.ready && st_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			if (compute && !skip && !go_q) begin
				go_q <= 1'b1;
			end else if (compute && (skip || alu_done)) begin
				go_q <= 1'b0;
				case (st_q)
					S_B_MUL1: begin acc_q <= lo + WORD_W'(k_q); st_q <= S_B_D33; end
					S_B_D33:  begin acc_q <= acc_q + lo; st_q <= S_B_RED1; end
					S_B_RED1: begin acc_q <= skip ? acc_q : hi; st_q <= S_B_MUL2; end
					S_B_MUL2: begin acc_q <= lo; st_q <= S_B_RED2; end
					S_B_RED2: begin acc_q <= skip ? acc_q : hi; st_q <= S_B_D29; end
					S_B_D29:  begin acc_q <= acc_q + lo; st_q <= S_B_RED3; end
					S_B_RED3: begin acc_q <= skip ? acc_q : hi; st_q <= S_B_NEXT; end
					S_A_RED1: begin acc_q <= skip ? acc_q : hi; st_q <= S_A_MUL1; end
					S_A_MUL1: begin acc_q <= lo; st_q <= S_A_RED2; end
					S_A_RED2: begin acc_q <= skip ? acc_q : hi; st_q <= S_A_MUL2; end
					S_A_MUL2: begin t_q <= hp_q + lo; st_q <= S_A_MUL3; end
					S_A_MUL3: begin acc_q <= lo; st_q <= S_A_RED3; end
					S_A_RED3: begin
						acc_q  <= skip ? acc_q : hi;
						hash_q <= skip ? acc_q : hi;
						pos_q  <= pos_q + 64'd1;
						pidx_q <= (pidx_q == AW'(SECRET_WORDS - 1)) ? '0 : pidx_q + AW'(1);
						st_q   <= last_q ? S_F_D1 : S_IDLE;
					end
					S_F_D1:   begin d1_q <= (lo < 64'd2) ? 64'd2 : lo; st_q <= S_F_Q1; end
					S_F_Q1:   begin acc_q <= acc_q + lo; st_q <= S_F_RED1; end
					S_F_RED1: begin acc_q <= skip ? acc_q : hi; st_q <= S_F_MUL; end
					S_F_MUL:  begin acc_q <= lo; st_q <= S_F_RED2; end
					S_F_RED2: begin acc_q <= skip ? acc_q : hi; st_q <= S_F_Q2; end
					S_F_Q2:   begin acc_q <= acc_q + lo; st_q <= S_F_RED3; end
					S_F_RED3: begin acc_q <= skip ? acc_q : hi; st_q <= S_F_REDT; end
					S_F_REDT: begin
						acc_q  <= skip ? acc_q : hi;
						kind_q <= RESULT_DIGEST;
						st_q   <= S_EMIT;
					end
					default: st_q <= S_IDLE;
				endcase
			end else begin
				unique case (st_q)
					S_IDLE: begin
						if (in_ch.valid) begin
							byte_q <= in_ch.byte_value;
							last_q <= in_ch.is_last;
							case (in_ch.command)
								CMD_BUILD: begin
									acc_q <= tsize_q;
									k_q   <= '0;
									st_q  <= S_B_MUL1;
								end
								CMD_ABSORB: st_q <= S_A_RD;
								CMD_FINISH: begin
									acc_q <= hash_q;
									st_q  <= S_F_D1;
								end
								default: st_q <= S_IDLE;
							endcase
						end
					end
					S_B_NEXT: begin
						if (k_q == AW'(SECRET_WORDS - 1)) begin
							kind_q <= RESULT_TABLE;
							acc_q  <= '0;
							st_q   <= S_EMIT;
						end else begin
							k_q  <= k_q + AW'(1);
							st_q <= S_B_MUL1;
						end
					end
					S_A_RD: begin
						s_q   <= ram_rd;
						acc_q <= hash_q + {56'd0, byte_q} + ram_rd;
						st_q  <= S_A_RED1;
					end
					S_EMIT: begin
						if (!out_valid_q || out_ch.ready) begin
							out_valid_q  <= 1'b1;
							out_kind_q   <= kind_q;
							out_digest_q <= acc_q[DIGEST_W-1:0];
							if (kind_q == RESULT_DIGEST) begin
								hash_q <= '0;
								pos_q  <= '0;
								pidx_q <= '0;
							end
							st_q <= S_IDLE;
						end
					end
					default: st_q <= st_q;
				endcase
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_kind = out_kind_q;
	assign out_ch.digest      = out_digest_q;
endmodule

### hw/rtl/mgbh_ram.sv
// generic single write port ram with registered read
module mgbh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 24
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/mgbh_alu.sv
// bit-serial 64-bit wrapping multiplier and restoring divider
module mgbh_alu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mgbh_pkg::alu_req_t    req,
	input  logic [63:0]           a,
	input  logic [63:0]           b,
	output logic                  done,
	output logic [63:0]           res_lo,
	output logic [63:0]           res_hi
);
	import mgbh_pkg::*;

	logic [WORD_W-1:0] a_q, b_q, p_q, rem_q;
	logic [5:0]        cnt_q;
	logic              busy_q, div_q, done_q;
	logic [WORD_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, a_q[WORD_W-1]};
	assign fits  = trial >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a;
			b_q   <= b;
			p_q   <= '0;
			rem_q <= '0;
			div_q <= req.div;
		end else if (busy_q) begin
			if (div_q) begin
				// one quotient bit per cycle, shifted into a_q
				rem_q <= fits ? WORD_W'(trial - {1'b0, b_q}) : trial[WORD_W-1:0];
				a_q   <= {a_q[WORD_W-2:0], fits};
			end else begin
				if (b_q[0]) begin
					p_q <= p_q + a_q;
				end
				a_q <= {a_q[WORD_W-2:0], 1'b0};
				b_q <= {1'b0, b_q[WORD_W-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign res_lo = div_q ? a_q : p_q;
	assign res_hi = rem_q;
endmodule

### bench/mgbh_scoreboard.sv
// checker for the modular golden byte hash: tracks config, predicts results, compares
`timescale 1ns / 100ps
module mgbh_scoreboard
	import mgbh_pkg::*;
#(
	parameter int SECRET_WORDS = SECRET_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	mgbh_in_if                  mon_in,
	mgbh_out_if                 mon_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [63:0]         pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  pending,
	output int                  digests_seen,
	output int                  tables_seen
);

	localparam int AW = SECRET_WORDS > 1 ? $clog2(SECRET_WORDS) : 1;

	typedef struct packed {
		logic        kind;
		logic [62:0] digest;
	} hash_result_t;

	logic [63:0] cfg_size, cfg_mod, cfg_hp, cfg_lp, cfg_aval;
	logic [32:0] cfg_root;
	logic [63:0] secrets [SECRET_WORDS];
	logic [63:0] acc_hash, acc_pos;
	hash_result_t want_q[$];

	function automatic logic [63:0] reduce(logic [63:0] x, logic [63:0] m);
		return (m != 0) ? x % m : x;
	endfunction

	function automatic logic [63:0] at_least_two(logic [63:0] d);
		return (d < 2) ? 64'd2 : d;
	endfunction

	function automatic logic [63:0] avalanche(logic [63:0] x);
		logic [63:0] d1, d2;
		d1 = at_least_two(cfg_mod / 3);
		d2 = at_least_two({31'd0, cfg_root});
		x = reduce(x + x / d1, cfg_mod);
		x = reduce(x * cfg_aval, cfg_mod);
		x = reduce(x + x / d2, cfg_mod);
		if (cfg_mod != cfg_size)
			x = reduce(x, cfg_size);
		return x;
	endfunction

	function automatic void queue_result(logic kind, logic [62:0] dig);
		hash_result_t r;
		r.kind = kind;
		r.digest = dig;
		want_q.insert(want_q.size(), r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] x, s, p;
		hash_result_t got, want;
		if (!arst_n) begin
			cfg_size <= 64'd1024;
			cfg_mod  <= 64'd1024;
			cfg_hp   <= 64'd631;
			cfg_lp   <= 64'd389;
			cfg_aval <= 64'd241;
			cfg_root <= 33'd32;
			for (int i = 0; i < SECRET_WORDS; i++)
				secrets[AW'(i)] <= '0;
			acc_hash <= '0;
			acc_pos <= '0;
			want_q.delete();
			errors = 0;
			digests_seen = 0;
			tables_seen = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:3])
					REG_TABLE_SIZE: cfg_size <= pwdata;
					REG_MODULUS:    cfg_mod <= pwdata;
					REG_HIGH_PRIME: cfg_hp <= pwdata;
					REG_LOW_PRIME:  cfg_lp <= pwdata;
					REG_AVALANCHE:  cfg_aval <= pwdata;
					REG_ROOT_DIV:   cfg_root <= pwdata[32:0];
					default: ;
				endcase
			end
			if (mon_out.valid && mon_out.ready) begin
				got.kind = mon_out.result_kind;
				got.digest = mon_out.digest;
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result kind=%0d digest=%0d", got.kind, got.digest);
				end else begin
					want = want_q.pop_front();
					if (got.kind == RESULT_DIGEST) digests_seen++;
					else tables_seen++;
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected kind=%0d digest=%0d, got kind=%0d digest=%0d",
								want.kind, want.digest, got.kind, got.digest);
					end
				end
			end
			if (mon_in.valid && mon_in.ready) begin
				case (mon_in.command)
					CMD_BUILD: begin
						x = cfg_size;
						for (int k = 0; k < SECRET_WORDS; k++) begin
							x = x * cfg_hp + 64'(k);
							x = reduce(x + x / 33, cfg_mod);
							x = reduce(x * cfg_lp, cfg_mod);
							x = reduce(x + x / 29, cfg_mod);
							secrets[AW'(k)] <= x;
						end
						queue_result(RESULT_TABLE, 63'd0);
					end
					CMD_ABSORB: begin
						p = acc_pos;
						s = secrets[AW'(p % SECRET_WORDS)];
						x = reduce(acc_hash + {56'd0, mon_in.byte_value} + s, cfg_mod);
						x = reduce(x * cfg_lp, cfg_mod);
						x = reduce(x * (cfg_hp + p * s), cfg_mod);
						if (mon_in.is_last) begin
							x = avalanche(x);
							queue_result(RESULT_DIGEST, x[62:0]);
							acc_hash <= '0;
							acc_pos <= '0;
						end else begin
							acc_hash <= x;
							acc_pos <= p + 64'd1;
						end
					end
					CMD_FINISH: begin
						x = avalanche(acc_hash);
						queue_result(RESULT_DIGEST, x[62:0]);
						acc_hash <= '0;
						acc_pos <= '0;
					end
					default: ;
				endcase
			end
			pending = want_q.size();
		end
	end

endmodule

### bench/modular_golden_byte_hash_tb.sv
// testbench top for the modular golden byte hash: stimulus, config, verdict
`timescale 1ns / 100ps
module modular_golden_byte_hash_tb;
	import mgbh_pkg::*;

	localparam int SETTLE = 600;
	localparam longint LIMIT = 6000000;
	localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [63:0] pwdata, prdata;
	int errors, pending, digests_seen, tables_seen;
	int snd_idle, rcv_idle, items_sent;
	int hold_left = 0;
	logic hold_start = 1'b0;
	longint cycles = 0;

	mgbh_in_if  in_ch();
	mgbh_out_if out_ch();

	modular_golden_byte_hash u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mgbh_scoreboard u_check (
		.clk(clk), .arst_n(arst_n), .mon_in(in_ch), .mon_out(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending),
		.digests_seen(digests_seen), .tables_seen(tables_seen)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_start) begin
			out_ch.ready <= 1'b0;
			hold_left <= 3000;
		end else if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	task automatic send(logic [1:0] cmd, logic [7:0] b, logic last);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.byte_value <= b;
		in_ch.is_last <= last;
		do @(posedge clk); while (!in_ch.ready);
		if (cmd != CMD_IGNORED) items_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(logic [63:0] n, logic [63:0] m, logic [63:0] hp,
			logic [63:0] lp, logic [63:0] av, logic [63:0] rd);
		reg_write(REG_TABLE_SIZE, n);
		reg_write(REG_MODULUS, m);
		reg_write(REG_HIGH_PRIME, hp);
		reg_write(REG_LOW_PRIME, lp);
		reg_write(REG_AVALANCHE, av);
		reg_write(REG_ROOT_DIV, rd);
	endtask

	function automatic logic [63:0] rand_below(int bits);
		logic [63:0] v;
		v = {$urandom, $urandom};
		return (bits >= 64) ? v : v & ((64'd1 << bits) - 1);
	endfunction

	// random config with N below 2^bits (at most 2^63), modulus N or N+1
	task automatic random_config(int bits);
		logic [63:0] n, rd;
		n = rand_below(bits);
		if (n < 2) n = 2;
		if (n > TOP) n = TOP;
		rd = rand_below(33);
		if (rd < 2) rd = 2;
		if (rd > 64'h1_0000_0000) rd = 64'h1_0000_0000;
		load_config(n, (n < TOP && $urandom_range(0, 1)) ? n + 1 : n,
			rand_below(bits) % TOP, rand_below(bits) % TOP, rand_below(bits) % TOP, rd);
	endtask

	task automatic message(int len, logic close_with_finish);
		for (int i = 0; i < len; i++)
			send(CMD_ABSORB, 8'($urandom), !close_with_finish && (i == len - 1));
		if (close_with_finish) send(CMD_FINISH, 8'($urandom), 1'($urandom));
	endtask

	task automatic random_phase(int target);
		int start, r;
		start = items_sent;
		send(CMD_BUILD, 8'($urandom), 1'($urandom));
		while (items_sent - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 70) message($urandom_range(1, 12), 1'b0);
			else if (r < 82) message($urandom_range(13, 60), 1'b0);
			else if (r < 90) message($urandom_range(0, 10), 1'b1);
			else if (r < 95) send(CMD_IGNORED, 8'($urandom), 1'($urandom));
			else if (r < 99) send(CMD_ABSORB, 8'($urandom), 1'($urandom));
			else send(CMD_BUILD, 8'($urandom), 1'($urandom));
		end
		send(CMD_FINISH, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		items_sent = 0;
		snd_idle = 0;
		rcv_idle = 0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_BUILD;
		in_ch.byte_value = '0;
		in_ch.is_last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset defaults
		send(CMD_BUILD, 8'h00, 1'b0);
		send(CMD_FINISH, 8'hff, 1'b1);            // empty message
		send(CMD_ABSORB, 8'h00, 1'b0);
		send(CMD_ABSORB, 8'hff, 1'b0);
		send(CMD_ABSORB, 8'haa, 1'b1);
		send(CMD_IGNORED, 8'h55, 1'b1);           // ignored command
		send(CMD_ABSORB, 8'h55, 1'b1);
		send(CMD_ABSORB, 8'h01, 1'b0);
		send(CMD_FINISH, 8'h00, 1'b0);            // finish mid-message
		send(CMD_ABSORB, 8'h80, 1'b0);
		send(CMD_BUILD, 8'h7f, 1'b1);             // rebuild mid-message
		send(CMD_ABSORB, 8'hfe, 1'b1);
		// sender waits for everything to come back
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		send(CMD_FINISH, 8'h00, 1'b0);
		drain();

		// low register values, with table size, modulus and root divisor at 2
		load_config(64'd2, 64'd2, 64'd0, 64'd0, 64'd0, 64'd2);
		send(CMD_BUILD, 8'h00, 1'b0);
		message(5, 1'b0);
		message(2, 1'b1);
		drain();
		// high register values up to 2^63, modulus differs from table size
		load_config(TOP, TOP - 64'd25, TOP, TOP - 64'd1, TOP, 64'h1_0000_0000);
		send(CMD_BUILD, 8'h00, 1'b0);
		message(30, 1'b0);
		message(3, 1'b1);
		drain();

		snd_idle = 17;
		rcv_idle = 49;
		random_config(20);
		random_phase(470);
		drain();

		snd_idle = 49;
		rcv_idle = 17;
		random_config(64);
		random_phase(470);
		drain();

		snd_idle = 0;
		rcv_idle = 0;
		random_config(33);
		// long receiver hold-off while the sender keeps offering short messages
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int i = 0; i < 6; i++) message(1, 1'b0);
		random_phase(450);
		drain();

		$display("sent %0d transactions across %0d register settings", items_sent, 6);
		$display("checked %0d digests and %0d table builds", digests_seen, tables_seen);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mgbh_pkg.sv
hw/rtl/mgbh_in_if.sv
hw/rtl/mgbh_out_if.sv
hw/rtl/mgbh_ram.sv
hw/rtl/mgbh_alu.sv
hw/rtl/modular_golden_byte_hash.sv
bench/mgbh_scoreboard.sv
bench/modular_golden_byte_hash_tb.sv
